// ----- hdl/ghps_pkg.sv -----
// ----------------------------------------------------------------------------
// ghps_pkg
// Shared types and constants for the gray histogram with peak scaling.
// ----------------------------------------------------------------------------
package ghps_pkg;

  localparam int unsigned BIN_COUNT    = 256;
  localparam int unsigned BIN_AW       = $clog2(BIN_COUNT);
  localparam int unsigned CANVAS_BITS  = 10;
  localparam int unsigned QUOT_BITS    = CANVAS_BITS;
  localparam int unsigned STEP_CNT_W   = $clog2(QUOT_BITS);
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = CANVAS_BITS'(125);
  localparam logic                    CFG_IDX_CANVAS = 1'b0;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic fetch;     // read the addressed bin
    logic sel_bin;   // address from bin_index rather than pixel_value
    logic rmw;       // write back incremented bin, update peak
    logic clr;       // drop all bins and the peak
    logic mul;       // scale count by canvas height, seed divider
    logic div_step;  // one restoring division step
    logic out_load;  // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/ghps_ram.sv -----
// ----------------------------------------------------------------------------
// ghps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ghps_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ghps_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghps_ctrl
// Request sequencer: accepts one request at a time and steps the datapath
// through bin update, bin clear, or fetch, scale, divide and result load.
// ----------------------------------------------------------------------------
module ghps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  ghps_pkg::sts_t      sts_i,
  output ghps_pkg::cmd_t      cmd_o
);

  ghps_pkg::state_e                     state_q, state_d;
  logic [ghps_pkg::STEP_CNT_W-1:0]      cnt_q, cnt_d;
  ghps_pkg::req_e                       req;
  logic                                 accept;
  logic                                 last_step;

  assign req       = ghps_pkg::req_e'(req_type_i);
  assign accept    = in_valid_i && (state_q == ghps_pkg::ST_IDLE);
  assign last_step = (cnt_q == ghps_pkg::STEP_CNT_W'(ghps_pkg::QUOT_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ghps_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ghps_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            ghps_pkg::REQ_PIXEL: state_d = ghps_pkg::ST_RMW;
            ghps_pkg::REQ_READ:  state_d = ghps_pkg::ST_MUL;
            default:             state_d = ghps_pkg::ST_IDLE;
          endcase
        end
      end
      ghps_pkg::ST_RMW: state_d = ghps_pkg::ST_IDLE;
      ghps_pkg::ST_MUL: begin
        state_d = ghps_pkg::ST_DIV;
        cnt_d   = '0;
      end
      ghps_pkg::ST_DIV: begin
        if (last_step) begin
          state_d = ghps_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ghps_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!sts_i.out_busy) begin
          state_d = ghps_pkg::ST_IDLE;
        end
      end
      default: state_d = ghps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ghps_pkg::ST_IDLE);
    case (state_q)
      ghps_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            ghps_pkg::REQ_PIXEL: cmd_o.fetch = 1'b1;
            ghps_pkg::REQ_READ: begin
              cmd_o.fetch   = 1'b1;
              cmd_o.sel_bin = 1'b1;
            end
            ghps_pkg::REQ_CLEAR: cmd_o.clr = 1'b1;
            default: cmd_o = '0;
          endcase
        end
      end
      ghps_pkg::ST_RMW:  cmd_o.rmw      = 1'b1;
      ghps_pkg::ST_MUL:  cmd_o.mul      = 1'b1;
      ghps_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      ghps_pkg::ST_DONE: cmd_o.out_load = !sts_i.out_busy;
      default:           cmd_o          = '0;
    endcase
  end

endmodule

// ----- hdl/ghps_dp.sv -----
// ----------------------------------------------------------------------------
// ghps_dp
// Histogram datapath: bin RAM with per-bin valid flags, peak register,
// count-by-height multiplier, radix-2 restoring divider and result register.
// ----------------------------------------------------------------------------
module ghps_dp #(
  parameter int unsigned COUNT_BITS = 17
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ghps_pkg::cmd_t                      cmd_i,
  output ghps_pkg::sts_t                      sts_o,
  input  logic [ghps_pkg::BIN_AW-1:0]         pixel_value_i,
  input  logic [ghps_pkg::BIN_AW-1:0]         bin_index_i,
  input  logic [ghps_pkg::CANVAS_BITS-1:0]    canvas_height_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [COUNT_BITS-1:0]               bin_count_o,
  output logic [COUNT_BITS-1:0]               peak_value_o,
  output logic [ghps_pkg::CANVAS_BITS-1:0]    bar_height_o
);

  localparam int unsigned PW = COUNT_BITS + ghps_pkg::CANVAS_BITS;
  localparam int unsigned QB = ghps_pkg::QUOT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [ghps_pkg::BIN_COUNT-1:0]  vld_q;
  logic                            vld_rd_q;
  logic [ghps_pkg::BIN_AW-1:0]     addr_q;
  logic [ghps_pkg::BIN_AW-1:0]     rd_addr;
  logic [COUNT_BITS-1:0]           ram_rdata;
  logic [COUNT_BITS-1:0]           rd_cnt;
  logic [COUNT_BITS-1:0]           inc_cnt;
  logic [COUNT_BITS-1:0]           peak_q;
  logic [COUNT_BITS-1:0]           count_q;
  logic [PW-1:0]                   prod;
  logic [COUNT_BITS-1:0]           rem_q, rem_d;
  logic [QB-1:0]                   quo_q;
  logic [COUNT_BITS:0]             trial;
  logic [COUNT_BITS:0]             diff;
  logic                            ge;
  logic                            out_valid_q;
  logic [COUNT_BITS-1:0]           bin_count_q;
  logic [COUNT_BITS-1:0]           peak_value_q;
  logic [ghps_pkg::CANVAS_BITS-1:0] bar_q;

  assign rd_addr = cmd_i.sel_bin ? bin_index_i : pixel_value_i;

  ghps_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (ghps_pkg::BIN_COUNT)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rmw),
    .waddr_i (addr_q),
    .wdata_i (inc_cnt),
    .re_i    (cmd_i.fetch),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // a bin not written since the last clear reads as zero
  assign rd_cnt  = vld_rd_q ? ram_rdata : '0;
  assign inc_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  assign prod = PW'(rd_cnt) * PW'(canvas_height_i);

  // restoring step: shift in the next dividend bit, subtract when it fits
  assign trial = {rem_q, quo_q[QB-1]};
  assign diff  = trial - {1'b0, peak_q};
  assign ge    = (trial >= {1'b0, peak_q});
  assign rem_d = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        vld_q  <= '0;
        peak_q <= '0;
      end else if (cmd_i.rmw) begin
        vld_q[addr_q] <= 1'b1;
        if (inc_cnt > peak_q) begin
          peak_q <= inc_cnt;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      addr_q   <= rd_addr;
      vld_rd_q <= vld_q[rd_addr];
    end
    if (cmd_i.mul) begin
      count_q <= rd_cnt;
      // quotient fits the canvas width since count never exceeds peak
      rem_q   <= prod[PW-1:QB];
      quo_q   <= prod[QB-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QB-2:0], ge};
    end
    if (cmd_i.out_load) begin
      bin_count_q  <= count_q;
      peak_value_q <= peak_q;
      bar_q        <= (peak_q == '0) ? '0 : quo_q;
    end
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign bin_count_o  = bin_count_q;
  assign peak_value_o = peak_value_q;
  assign bar_height_o = bar_q;

endmodule

// ----- hdl/gray_histogram_with_peak_scaling.sv -----
// ----------------------------------------------------------------------------
// gray_histogram_with_peak_scaling
// 256-bin histogram of 8-bit gray pixels with a running peak. A pixel
// request reads the bin RAM, then does a saturating write-back and peak
// update; a clear request clears all bins at once through per-bin valid
// flags, so no clearing pass runs after reset; a read request runs a bin
// fetch, a count-by-height multiply, 10 radix-2 steps of the restoring
// divider and a result load, and waits before the load while the previous
// result beat is still stalled on the output. The divider sets the read
// latency, the read-then-write bin RAM sets the pixel rate. Requests are
// taken one at a time; the next request is taken while a finished result
// still waits on the output. canvas_height is at register byte address 0.
// ----------------------------------------------------------------------------
module gray_histogram_with_peak_scaling #(
  parameter int unsigned COUNT_BITS = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [ghps_pkg::BIN_AW-1:0]       pixel_value_i,
  input  logic [ghps_pkg::BIN_AW-1:0]       bin_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COUNT_BITS-1:0]             bin_count_o,
  output logic [COUNT_BITS-1:0]             peak_value_o,
  output logic [ghps_pkg::CANVAS_BITS-1:0]  bar_height_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ghps_pkg::APB_AW-1:0]       paddr,
  input  logic [ghps_pkg::APB_DW-1:0]       pwdata,
  output logic [ghps_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  logic [ghps_pkg::CANVAS_BITS-1:0] canvas_q;
  logic                             canvas_sel;
  ghps_pkg::cmd_t                   cmd;
  ghps_pkg::sts_t                   sts;

  assign pready     = 1'b1;
  assign canvas_sel = (paddr[ghps_pkg::APB_AW-1] == ghps_pkg::CFG_IDX_CANVAS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_q <= ghps_pkg::CANVAS_RESET;
    end else if (psel && penable && pwrite && canvas_sel) begin
      canvas_q <= pwdata[ghps_pkg::CANVAS_BITS-1:0];
    end
  end

  assign prdata = canvas_sel ? ghps_pkg::APB_DW'(canvas_q) : '0;

  ghps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ghps_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_value_i   (pixel_value_i),
    .bin_index_i     (bin_index_i),
    .canvas_height_i (canvas_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bin_count_o     (bin_count_o),
    .peak_value_o    (peak_value_o),
    .bar_height_o    (bar_height_o)
  );

endmodule

// ----- hdl/ghps_chk.sv -----
// ----------------------------------------------------------------------------
// ghps_chk
// Port-level checks for the gray histogram, bound to the top level.
// ----------------------------------------------------------------------------
module ghps_chk #(
  parameter int unsigned COUNT_BITS = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [COUNT_BITS-1:0]             bin_count_o,
  input  logic [COUNT_BITS-1:0]             peak_value_o,
  input  logic [ghps_pkg::CANVAS_BITS-1:0]  bar_height_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_count_o)
      && $stable(peak_value_o) && $stable(bar_height_o))
    else $error("stalled result beat changed");

  // a bin never exceeds the peak
  a_bin_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bin_count_o <= peak_value_o)
    else $error("bin count above peak");

  // empty histogram gives a zero bar
  a_zero_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (peak_value_o == '0) |-> (bar_height_o == '0) && (bin_count_o == '0))
    else $error("nonzero result with zero peak");

  // a pixel or read beat keeps the input stalled for the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o
      && (req_type_i == ghps_pkg::REQ_PIXEL || req_type_i == ghps_pkg::REQ_READ)
      |=> in_stall_o)
    else $error("input taken during bin update");

endmodule

bind gray_histogram_with_peak_scaling ghps_chk #(
  .COUNT_BITS (COUNT_BITS)
) u_ghps_chk (.*);
